>>> sv/assert_macros.svh
// Assertion macros for the vertex remap compaction block.
// Needs clk and arst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock, off while in reset.
`define VRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent implies consequent on the next clock.
`define VRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/vrc_pkg.sv
// Shared types and constants of the vertex remap compaction block.
// No dependencies.
package vrc_pkg;

	localparam int MAX_VERTICES = 4096;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = IDX_W + 1;
	localparam int ENTRY_W      = IDX_W + 1;
	localparam int FIFO_DEPTH   = 3;
	localparam int FIFO_PTR_W   = 2;

	localparam logic [1:0] KIND_KEPT     = 2'd0;
	localparam logic [1:0] KIND_REMOVED  = 2'd1;
	localparam logic [1:0] KIND_REPLACED = 2'd2;

	// Write port of the forward map; also used for forwarding.
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   addr;
		logic [ENTRY_W-1:0] data; // msb: removed, rest: new index
	} wb_t;

	// Item state leaving the front stage.
	typedef struct packed {
		logic [CNT_W-1:0]   src;
		logic               in_range;
		logic               lookup;
		logic [IDX_W-1:0]   new_idx;
		logic               removed;
		logic               new_point;
		logic               bad;
		logic [CNT_W-1:0]   kept;
		logic               last;
		logic               fwd_hit;
		logic [ENTRY_W-1:0] fwd_data;
	} stage_t;

	// One result item.
	typedef struct packed {
		logic [IDX_W-1:0] source_index;
		logic [IDX_W-1:0] new_index;
		logic             removed;
		logic             is_new_point;
		logic             bad_target;
		logic [CNT_W-1:0] kept_count;
		logic             last_out;
	} res_t;

endpackage

>>> sv/vertex_remap_compaction_core.sv
// An accepted vertex reads the map, is registered in stage 1, is resolved there and is
// pushed into the result queue. Throughput: one vertex per cycle; the forward map has
// one read port, used once per vertex, and one write port, used once per vertex in
// range. Input stalls only while stage 1 plus the three-entry result queue hold three
// results. Reset (arst_n low, asynchronous): counters and queue cleared; the forward
// map is not cleared and needs no clearing pass.
`include "assert_macros.svh"
module vertex_remap_compaction_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 entry_kind,
	input  logic [vrc_pkg::IDX_W-1:0]  target_index,
	input  logic                       last_vertex,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [vrc_pkg::IDX_W-1:0]  source_index,
	output logic [vrc_pkg::IDX_W-1:0]  new_index,
	output logic                       removed,
	output logic                       is_new_point,
	output logic                       bad_target,
	output logic [vrc_pkg::CNT_W-1:0]  kept_count,
	output logic                       last_out
);

	// Stage 0: counters assign the source index and classify the entry; the map
	// is read at the target. Stage 1: map data (or data being written in the
	// very cycle of that read, forwarded) resolves replaced vertices, and the
	// result is written back at the source index if in range and pushed into the queue.
	// Stage 1 never stalls, so read data is always consumed the cycle after.

	logic                            in_xfer;
	logic                            out_xfer;
	vrc_pkg::stage_t                 st_s0;
	vrc_pkg::stage_t                 st_s1;
	logic                            valid_s1;
	vrc_pkg::wb_t                    wb;
	logic [vrc_pkg::ENTRY_W-1:0]     ram_rdata;
	logic [vrc_pkg::ENTRY_W-1:0]     entry;
	logic                            rem_fin;
	logic [vrc_pkg::IDX_W-1:0]       idx_fin;
	vrc_pkg::res_t                   res;
	vrc_pkg::res_t                   head;
	logic [vrc_pkg::FIFO_PTR_W-1:0]  q_count;
	logic [vrc_pkg::FIFO_PTR_W:0]    occupancy;
	logic                            q_full;
	logic                            flags_ok;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// Room for the item in stage 1 plus the new one.
	assign occupancy = (vrc_pkg::FIFO_PTR_W+1)'(q_count) + (vrc_pkg::FIFO_PTR_W+1)'(valid_s1);
	assign in_ready  = occupancy < (vrc_pkg::FIFO_PTR_W+1)'(vrc_pkg::FIFO_DEPTH);

	vrc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_xfer),
		.entry_kind   (entry_kind),
		.target_index (target_index),
		.last_vertex  (last_vertex),
		.wb           (wb),
		.st           (st_s0)
	);

	vrc_map_ram u_map (
		.clk     (clk),
		.rd_en   (in_xfer),
		.rd_addr (target_index),
		.rd_data (ram_rdata),
		.wb      (wb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			st_s1 <= st_s0;
		end
	end

	// Replaced vertex: target result is final already, so one lookup collapses
	// the chain and carries removal along.
	assign entry = st_s1.fwd_hit ? st_s1.fwd_data : ram_rdata;

	always_comb begin
		if (st_s1.lookup) begin
			rem_fin = entry[vrc_pkg::ENTRY_W-1];
			idx_fin = rem_fin ? '0 : entry[vrc_pkg::IDX_W-1:0];
		end else begin
			rem_fin = st_s1.removed;
			idx_fin = st_s1.new_idx;
		end
	end

	// Writeback; a vertex past capacity stores nothing.
	assign wb.en   = valid_s1 && st_s1.in_range;
	assign wb.addr = st_s1.src[vrc_pkg::IDX_W-1:0];
	assign wb.data = {rem_fin, idx_fin};

	always_comb begin
		res.source_index = st_s1.src[vrc_pkg::IDX_W-1:0];
		res.new_index    = idx_fin;
		res.removed      = rem_fin;
		res.is_new_point = st_s1.new_point;
		res.bad_target   = st_s1.bad;
		res.kept_count   = st_s1.kept;
		res.last_out     = st_s1.last;
	end

	vrc_out_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.din       (res),
		.pop       (out_xfer),
		.dout      (head),
		.not_empty (out_valid),
		.count     (q_count)
	);

	assign source_index = head.source_index;
	assign new_index    = head.new_index;
	assign removed      = head.removed;
	assign is_new_point = head.is_new_point;
	assign bad_target   = head.bad_target;
	assign kept_count   = head.kept_count;
	assign last_out     = head.last_out;

	assign q_full   = q_count == vrc_pkg::FIFO_PTR_W'(vrc_pkg::FIFO_DEPTH);
	assign flags_ok = (!bad_target || removed) && (!is_new_point || !removed);

	// Queue must have room whenever stage 1 pushes.
	`VRC_ASSERT(a_no_overflow, !(valid_s1 && !out_xfer && q_full), "result queue overflow")
	// Every accepted vertex reaches stage 1 next cycle.
	`VRC_ASSERT_NEXT(a_s1_follows, in_xfer, valid_s1, "accepted vertex lost before stage 1")
	// Flagged or kept results are consistent with the removed mark.
	`VRC_ASSERT(a_flags, !out_valid || flags_ok, "inconsistent result flags")

endmodule

>>> sv/vrc_map_ram.sv
// Forward map storage: one write port, one registered read port.
// Depends on vrc_pkg.
module vrc_map_ram (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [vrc_pkg::IDX_W-1:0]    rd_addr,
	output logic [vrc_pkg::ENTRY_W-1:0]  rd_data,
	input  vrc_pkg::wb_t                 wb
);

	logic [vrc_pkg::ENTRY_W-1:0] mem [vrc_pkg::MAX_VERTICES];

	always_ff @(posedge clk) begin
		if (wb.en) begin
			mem[wb.addr] <= wb.data;
		end
	end

	// read before write on the same address; caller forwards
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> sv/vrc_front.sv
// Front stage: vertex and kept counters, entry classification, forward match.
// Depends on vrc_pkg.
module vrc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [1:0]                 entry_kind,
	input  logic [vrc_pkg::IDX_W-1:0]  target_index,
	input  logic                       last_vertex,
	input  vrc_pkg::wb_t               wb,
	output vrc_pkg::stage_t            st
);

	logic [vrc_pkg::CNT_W-1:0] vcnt_q;
	logic [vrc_pkg::CNT_W-1:0] kcnt_q;
	logic [vrc_pkg::CNT_W-1:0] kcnt_next;

	always_comb begin
		st           = '0;
		st.src       = vcnt_q;
		st.in_range  = vcnt_q < vrc_pkg::CNT_W'(vrc_pkg::MAX_VERTICES);
		st.last      = last_vertex;
		st.fwd_hit   = wb.en && (wb.addr == target_index);
		st.fwd_data  = wb.data;
		kcnt_next    = kcnt_q;
		if (!st.in_range) begin
			st.bad     = 1'b1;
			st.removed = 1'b1;
		end else begin
			unique case (entry_kind)
				vrc_pkg::KIND_KEPT: begin
					st.new_idx   = kcnt_q[vrc_pkg::IDX_W-1:0];
					st.new_point = 1'b1;
					kcnt_next    = kcnt_q + 1'b1;
				end
				vrc_pkg::KIND_REPLACED: begin
					if ({1'b0, target_index} >= vcnt_q) begin
						st.bad     = 1'b1;
						st.removed = 1'b1;
					end else begin
						st.lookup  = 1'b1;
					end
				end
				default: begin
					st.removed = 1'b1;
				end
			endcase
		end
		st.kept = kcnt_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= '0;
			kcnt_q <= '0;
		end else if (accept) begin
			if (last_vertex) begin
				vcnt_q <= '0;
				kcnt_q <= '0;
			end else begin
				if (st.in_range) begin
					vcnt_q <= vcnt_q + 1'b1;
				end
				kcnt_q <= kcnt_next;
			end
		end
	end

endmodule

>>> sv/vrc_out_fifo.sv
// Three-entry result queue decoupling the pipeline from the output channel.
// Depends on vrc_pkg.
module vrc_out_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  vrc_pkg::res_t                   din,
	input  logic                            pop,
	output vrc_pkg::res_t                   dout,
	output logic                            not_empty,
	output logic [vrc_pkg::FIFO_PTR_W-1:0]  count
);

	vrc_pkg::res_t                  buf_q [vrc_pkg::FIFO_DEPTH];
	logic [vrc_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [vrc_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [vrc_pkg::FIFO_PTR_W-1:0] count_q;

	function automatic logic [vrc_pkg::FIFO_PTR_W-1:0] ptr_inc(
		input logic [vrc_pkg::FIFO_PTR_W-1:0] p);
		ptr_inc = (p == vrc_pkg::FIFO_PTR_W'(vrc_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign dout      = buf_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> tb/vertex_remap_compaction_core_tb.sv
// Testbench for vertex_remap_compaction_core: compaction of mesh vertices into dense indices.
// Depends on vrc_pkg (widths, kind codes, result struct) and the core RTL; self-checking.
`timescale 1ns / 1ps

module vertex_remap_compaction_core_tb;

	// Code 3 is not defined by the package; the core must treat it as a plain removal.
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	// Input transfer to result shown, plus margin for the final quiet check.
	localparam int TAIL_CYCLES = 12;
	localparam int MAX_PRINTS  = 50;

	logic                        clk          = 1'b0;
	logic                        arst_n       = 1'b0;
	logic                        in_valid     = 1'b0;
	logic                        in_ready;
	logic [1:0]                  entry_kind   = vrc_pkg::KIND_KEPT;
	logic [vrc_pkg::IDX_W-1:0]   target_index = '0;
	logic                        last_vertex  = 1'b0;
	logic                        out_valid;
	logic                        out_ready    = 1'b0;
	logic [vrc_pkg::IDX_W-1:0]   source_index;
	logic [vrc_pkg::IDX_W-1:0]   new_index;
	logic                        removed;
	logic                        is_new_point;
	logic                        bad_target;
	logic [vrc_pkg::CNT_W-1:0]   kept_count;
	logic                        last_out;

	// Predictor state: per-vertex entry (msb removed, rest new index) plus mesh counters.
	logic [vrc_pkg::ENTRY_W-1:0] fwd_remap [vrc_pkg::MAX_VERTICES];
	logic [vrc_pkg::CNT_W-1:0]   src_count  = '0;
	logic [vrc_pkg::CNT_W-1:0]   kept_total = '0;

	vrc_pkg::res_t               pending_remaps [$];
	int unsigned                 mismatch_count = 0;
	int unsigned                 result_count   = 0;
	// When set, neither side inserts gaps: back-to-back stretches.
	bit                          no_idle        = 1'b0;

	vertex_remap_compaction_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.entry_kind   (entry_kind),
		.target_index (target_index),
		.last_vertex  (last_vertex),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.source_index (source_index),
		.new_index    (new_index),
		.removed      (removed),
		.is_new_point (is_new_point),
		.bad_target   (bad_target),
		.kept_count   (kept_count),
		.last_out     (last_out)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop, well beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("** vertex_remap_compaction_core: FAILED **");
		$finish;
	end

	//--------------------------------------------------------------------
	// Predictor: one call per accepted vertex, in transfer order.
	// Out-of-range vertices store nothing and leave the counter pinned at
	// capacity; bad targets are stored as removed so later replacements of
	// them carry the removal. The mesh counters restart after the last vertex.
	//--------------------------------------------------------------------
	function automatic vrc_pkg::res_t remap_vertex(input logic [1:0] kind,
			input logic [vrc_pkg::IDX_W-1:0] tgt, input logic last);
		vrc_pkg::res_t               r;
		logic [vrc_pkg::ENTRY_W-1:0] entry;
		r = '0;
		r.source_index = src_count[vrc_pkg::IDX_W-1:0];
		r.last_out     = last;
		if (src_count >= vrc_pkg::CNT_W'(vrc_pkg::MAX_VERTICES)) begin
			r.bad_target = 1'b1;
			r.removed    = 1'b1;
		end else begin
			case (kind)
				vrc_pkg::KIND_KEPT: begin
					r.new_index    = kept_total[vrc_pkg::IDX_W-1:0];
					r.is_new_point = 1'b1;
					kept_total     = kept_total + 1'b1;
				end
				vrc_pkg::KIND_REPLACED: begin
					if ({1'b0, tgt} >= src_count) begin
						r.bad_target = 1'b1;
						r.removed    = 1'b1;
					end else begin
						// target lies below source, so its entry is final already
						entry = fwd_remap[tgt];
						if (entry[vrc_pkg::ENTRY_W-1])
							r.removed = 1'b1;
						else
							r.new_index = entry[vrc_pkg::IDX_W-1:0];
					end
				end
				default: r.removed = 1'b1;
			endcase
			fwd_remap[src_count[vrc_pkg::IDX_W-1:0]] = r.removed
				? {1'b1, {vrc_pkg::IDX_W{1'b0}}} : {1'b0, r.new_index};
			src_count = src_count + 1'b1;
		end
		r.kept_count = kept_total;
		if (last) begin
			src_count  = '0;
			kept_total = '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [vrc_pkg::CNT_W-1:0] got,
			input logic [vrc_pkg::CNT_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
				result_count, name, got, want));
	endtask

	// Result checker: every output transfer against the oldest pending remap.
	always @(posedge clk) begin
		vrc_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_remaps.size() == 0) begin
				report_mismatch($sformatf("result %0d with no vertex pending", result_count));
			end else begin
				want = pending_remaps.pop_front();
				check_field("source_index", vrc_pkg::CNT_W'(source_index),
					vrc_pkg::CNT_W'(want.source_index));
				check_field("new_index", vrc_pkg::CNT_W'(new_index),
					vrc_pkg::CNT_W'(want.new_index));
				check_field("removed", vrc_pkg::CNT_W'(removed),
					vrc_pkg::CNT_W'(want.removed));
				check_field("is_new_point", vrc_pkg::CNT_W'(is_new_point),
					vrc_pkg::CNT_W'(want.is_new_point));
				check_field("bad_target", vrc_pkg::CNT_W'(bad_target),
					vrc_pkg::CNT_W'(want.bad_target));
				check_field("kept_count", kept_count, want.kept_count);
				check_field("last_out", vrc_pkg::CNT_W'(last_out),
					vrc_pkg::CNT_W'(want.last_out));
			end
			result_count++;
		end
	end

	// Receiver: a random stall (none when no_idle is set) ahead of each result transfer.
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : int'($urandom_range(0, 4));
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// One vertex transfer. Valid is only dropped when a gap follows, so a
	// back-to-back vertex never sees valid lowered and raised in one step.
	task automatic send_vertex(input logic [1:0] kind, input logic [vrc_pkg::IDX_W-1:0] tgt,
			input logic last);
		int gap;
		gap = no_idle ? 0 : int'($urandom_range(0, 4));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		entry_kind   <= kind;
		target_index <= tgt;
		last_vertex  <= last;
		do @(posedge clk); while (!in_ready);
		pending_remaps.push_back(remap_vertex(kind, tgt, last));
	endtask

	// Sender holds off until every pending result has been seen.
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		while (pending_remaps.size() != 0) @(posedge clk);
	endtask

	// Kept numbering, plain removal, replacement chains, removal carried along
	// a chain, and the undefined kind.
	task automatic test_remap_basics();
		send_vertex(vrc_pkg::KIND_KEPT,     12'd0,    1'b0); // src 0 -> new 0
		send_vertex(vrc_pkg::KIND_REMOVED,  12'hFFF,  1'b0); // src 1 removed
		send_vertex(vrc_pkg::KIND_REPLACED, 12'd0,    1'b0); // src 2 -> 0
		send_vertex(vrc_pkg::KIND_REPLACED, 12'd1,    1'b0); // src 3 -> removed root
		send_vertex(vrc_pkg::KIND_REPLACED, 12'd2,    1'b0); // src 4 chain 4->2->0
		send_vertex(KIND_UNUSED,            12'hFFF,  1'b0); // src 5 removed, no flag
		send_vertex(vrc_pkg::KIND_REPLACED, 12'd5,    1'b0); // src 6 -> removed
		send_vertex(vrc_pkg::KIND_KEPT,     12'hFFF,  1'b0); // src 7 -> new 1
		send_vertex(vrc_pkg::KIND_REPLACED, 12'd7,    1'b1); // src 8 -> new 1, mesh end
	endtask

	// Targets not below the source, and replacement of a flagged vertex.
	task automatic test_bad_targets();
		send_vertex(vrc_pkg::KIND_REPLACED, 12'd0,    1'b0); // target equals source 0
		send_vertex(vrc_pkg::KIND_KEPT,     12'd0,    1'b0);
		send_vertex(vrc_pkg::KIND_REPLACED, 12'd2,    1'b0); // target equals source 2
		send_vertex(vrc_pkg::KIND_REPLACED, 12'hFFF,  1'b0); // far above source
		send_vertex(vrc_pkg::KIND_REPLACED, 12'd2,    1'b0); // flagged vertex reads as removed
		send_vertex(vrc_pkg::KIND_REPLACED, 12'd1,    1'b0);
		send_vertex(vrc_pkg::KIND_KEPT,     12'd0,    1'b1);
		// single-vertex meshes
		send_vertex(vrc_pkg::KIND_KEPT,     12'd0,    1'b1);
		send_vertex(vrc_pkg::KIND_REMOVED,  12'd0,    1'b1);
	endtask

	// Random meshes: mostly short, mostly legal targets, some noise.
	task automatic test_random_meshes(input int unsigned n_vertices);
		int unsigned               sent;
		int unsigned               mesh_len;
		int unsigned               pos;
		int unsigned               pick;
		logic [1:0]                kind;
		logic [vrc_pkg::IDX_W-1:0] tgt;
		sent = 0;
		while (sent < n_vertices) begin
			mesh_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
				: $urandom_range(1, 40);
			no_idle  = ($urandom_range(0, 5) == 0);
			for (pos = 0; pos < mesh_len; pos++) begin
				pick = $urandom_range(0, 99);
				tgt  = vrc_pkg::IDX_W'($urandom_range(0, vrc_pkg::MAX_VERTICES - 1));
				if (pick < 35) begin
					kind = vrc_pkg::KIND_KEPT;
				end else if (pick < 50) begin
					kind = vrc_pkg::KIND_REMOVED;
				end else if (pick < 85) begin
					kind = (pos == 0) ? vrc_pkg::KIND_KEPT : vrc_pkg::KIND_REPLACED;
					if (pos != 0)
						tgt = vrc_pkg::IDX_W'($urandom_range(0, pos - 1));
				end else if (pick < 93) begin
					kind = vrc_pkg::KIND_REPLACED;
					tgt  = vrc_pkg::IDX_W'($urandom_range(pos, vrc_pkg::MAX_VERTICES - 1));
				end else begin
					kind = KIND_UNUSED;
				end
				send_vertex(kind, tgt, pos == mesh_len - 1);
				sent++;
			end
			if ($urandom_range(0, 19) == 0)
				wait_results_drained();
		end
		no_idle = 1'b0;
	endtask

	// Fill the map with kept vertices up to capacity, then overflow; the next
	// mesh must start from zero again.
	task automatic test_capacity_overflow();
		int unsigned               i;
		logic [vrc_pkg::IDX_W-1:0] tgt;
		no_idle = 1'b1;
		for (i = 0; i < vrc_pkg::MAX_VERTICES; i++) begin
			if (i == vrc_pkg::MAX_VERTICES / 2)
				no_idle = 1'b0;
			tgt = vrc_pkg::IDX_W'($urandom_range(0, vrc_pkg::MAX_VERTICES - 1));
			send_vertex(vrc_pkg::KIND_KEPT, tgt, 1'b0);
		end
		send_vertex(vrc_pkg::KIND_REPLACED, 12'd0,   1'b0);
		send_vertex(vrc_pkg::KIND_KEPT,     12'hFFF, 1'b0);
		send_vertex(vrc_pkg::KIND_REMOVED,  12'd0,   1'b1);
		send_vertex(vrc_pkg::KIND_REPLACED, 12'd0,   1'b0); // src 0 again
		send_vertex(vrc_pkg::KIND_KEPT,     12'd0,   1'b1);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_remap_basics();
		wait_results_drained();
		test_bad_targets();
		wait_results_drained();
		test_random_meshes(400);
		wait_results_drained();
		test_capacity_overflow();
		wait_results_drained();

		// quiet tail catches stray results
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("** vertex_remap_compaction_core: PASSED **");
		else
			$display("** vertex_remap_compaction_core: FAILED **");
		$finish;
	end

endmodule
